@@ rtl/bph_pkg.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure package
// Shared widths, register codes, reset values and types for the buffer
// pressure flow controller.
// ----------------------------------------------------------------------------
package bph_pkg;

  // Field and register widths
  localparam int unsigned CountBits      = 24;
  localparam int unsigned SampleRateBits = 19;
  localparam int unsigned ThreshBits     = 18;
  localparam int unsigned FracBits       = 16;
  localparam int unsigned ModeBits       = 2;
  localparam int unsigned PctBits        = 7;
  localparam int unsigned LatBits        = 16;
  localparam int unsigned CfgIdxBits     = 3;
  localparam int unsigned CfgDataBits    = 19;

  // Divider and comparator sizing
  localparam int unsigned NumBits  = 34;
  localparam int unsigned DivSteps = NumBits;
  localparam int unsigned StepBits = $clog2(DivSteps + 1);
  localparam int unsigned ProdBits = ThreshBits + CountBits;
  localparam int unsigned NumThr   = 4;
  localparam int unsigned ThrBits  = $clog2(NumThr);

  // Scale factors and saturation limits
  localparam int unsigned PctScale = 100;
  localparam int unsigned LatScale = 1000;
  localparam logic [PctBits-1:0] PctMax = PctBits'(100);
  localparam logic [LatBits-1:0] LatMax = {LatBits{1'b1}};

  // Command queue sizing
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrBits    = $clog2(QueueDepth);
  localparam int unsigned QCntBits   = $clog2(QueueDepth + 1);

  // Configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgSampleRate   = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgDegEnter     = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgEmerEnter    = CfgIdxBits'(2);
  localparam logic [CfgIdxBits-1:0] CfgDegRelease   = CfgIdxBits'(3);
  localparam logic [CfgIdxBits-1:0] CfgEmerRelease  = CfgIdxBits'(4);

  // Configuration reset values
  localparam logic [SampleRateBits-1:0] SampleRateRst = SampleRateBits'(48000);
  localparam logic [ThreshBits-1:0]     DegEnterRst   = ThreshBits'(45875);
  localparam logic [ThreshBits-1:0]     EmerEnterRst  = ThreshBits'(58982);
  localparam logic [ThreshBits-1:0]     DegReleaseRst = ThreshBits'(32768);
  localparam logic [ThreshBits-1:0]     EmerReleaseRst = ThreshBits'(52429);

  // Threshold slots in the comparator sequence
  localparam logic [ThrBits-1:0] ThrDegEnter    = ThrBits'(0);
  localparam logic [ThrBits-1:0] ThrEmerEnter   = ThrBits'(1);
  localparam logic [ThrBits-1:0] ThrDegRelease  = ThrBits'(2);
  localparam logic [ThrBits-1:0] ThrEmerRelease = ThrBits'(3);

  // Flow mode codes
  typedef enum logic [ModeBits-1:0] {
    ModeNormal    = 2'd0,
    ModeDegraded  = 2'd1,
    ModeEmergency = 2'd2
  } mode_e;

  // Configuration register set
  typedef struct packed {
    logic [SampleRateBits-1:0] sample_rate;
    logic [ThreshBits-1:0]     degraded_enter;
    logic [ThreshBits-1:0]     emergency_enter;
    logic [ThreshBits-1:0]     degraded_release;
    logic [ThreshBits-1:0]     emergency_release;
  } cfg_t;

  // Classified command handed from the front end to the back end
  typedef struct packed {
    logic [CountBits-1:0] fill;
    logic [CountBits-1:0] cap;
    logic                 zero_cap;
  } cmd_t;

endpackage

@@ rtl/bph_if.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure channels
// Valid/ready channels for the level samples and the flow reports.
// ----------------------------------------------------------------------------

// Level sample channel
interface bph_in_if;
  logic                            valid;
  logic                            ready;
  logic [bph_pkg::CountBits-1:0]   fill_level;
  logic [bph_pkg::CountBits-1:0]   buffer_capacity;

  modport source (output valid, fill_level, buffer_capacity, input ready);
  modport sink   (input valid, fill_level, buffer_capacity, output ready);
endinterface

// Flow report channel
interface bph_out_if;
  logic                          valid;
  logic                          ready;
  logic [bph_pkg::ModeBits-1:0]  flow_mode;
  logic [bph_pkg::PctBits-1:0]   pressure_percent;
  logic [bph_pkg::LatBits-1:0]   latency_ms;

  modport source (output valid, flow_mode, pressure_percent, latency_ms, input ready);
  modport sink   (input valid, flow_mode, pressure_percent, latency_ms, output ready);
endinterface

@@ rtl/bph_front.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure front end
// Accepts level samples, flags a zero capacity and holds the classified
// command in a register stage until the queue takes it.
// ----------------------------------------------------------------------------
module bph_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  bph_in_if.sink            in_i,
  output bph_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);

  logic          slot_valid_q, slot_valid_d;
  bph_pkg::cmd_t cmd_q;
  logic          in_fire;

  // The stage takes a new sample whenever it is empty or being drained.
  assign in_i.ready = !slot_valid_q || cmd_ready_i;
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    slot_valid_d = slot_valid_q;
    if (in_fire) begin
      slot_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= 1'b0;
    end else begin
      slot_valid_q <= slot_valid_d;
    end
  end

  // Classify the sample: a zero capacity bypasses all arithmetic.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q.fill     <= in_i.fill_level;
      cmd_q.cap      <= in_i.buffer_capacity;
      cmd_q.zero_cap <= (in_i.buffer_capacity == '0);
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = slot_valid_q;

endmodule

@@ rtl/bph_queue.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure command queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module bph_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bph_pkg::cmd_t     cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output bph_pkg::cmd_t     cmd_o,
  output logic              empty_o
);

  bph_pkg::cmd_t                   mem_q [bph_pkg::QueueDepth];
  logic [bph_pkg::PtrBits-1:0]     wr_ptr_q, rd_ptr_q;
  logic [bph_pkg::QCntBits-1:0]    cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == bph_pkg::QCntBits'(bph_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Occupancy tracking
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + bph_pkg::QCntBits'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - bph_pkg::QCntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + bph_pkg::PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + bph_pkg::PtrBits'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/bph_back.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure back end
// Runs the percent and latency dividers, the threshold comparisons and
// the flow mode state machine, and holds the result in an output register.
// ----------------------------------------------------------------------------
module bph_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bph_pkg::cfg_t     cfg_i,
  input  bph_pkg::cmd_t     cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_pop_o,
  bph_out_if.source         out_o
);

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StLoad   = 4'b0010,
    StDiv    = 4'b0100,
    StFinish = 4'b1000
  } back_state_e;

  back_state_e state_q, state_d;

  logic [bph_pkg::CountBits-1:0]      fill_q, cap_q;
  logic                               zero_q;
  logic [bph_pkg::StepBits-1:0]       cnt_q, cnt_m1;
  logic [bph_pkg::NumBits-1:0]        pct_num_q, lat_num_q;
  logic [bph_pkg::CountBits-1:0]      pct_rem_q;
  logic [bph_pkg::SampleRateBits-1:0] lat_rem_q;
  logic [bph_pkg::ProdBits-1:0]       prod_q;
  logic [bph_pkg::NumThr-1:0]         flags_q;

  bph_pkg::mode_e                     mode_q, mode_nxt;
  logic [bph_pkg::PctBits-1:0]        last_pct_q, pct_new;
  logic [bph_pkg::LatBits-1:0]        last_lat_q, lat_new;

  logic                               out_valid_q;
  logic [bph_pkg::ModeBits-1:0]       out_mode_q;
  logic [bph_pkg::PctBits-1:0]        out_pct_q;
  logic [bph_pkg::LatBits-1:0]        out_lat_q;

  logic                               out_free, finish_fire, div_last;
  logic [bph_pkg::CountBits:0]        pct_trial;
  logic                               pct_ge;
  logic [bph_pkg::SampleRateBits:0]   lat_trial;
  logic                               lat_ge;
  logic [bph_pkg::ThreshBits-1:0]     thr_sel;
  logic [bph_pkg::ProdBits-1:0]       fill_scaled;
  logic                               ge_de, ge_ee, ge_dr, ge_er;

  assign out_free    = !out_valid_q || out_o.ready;
  assign finish_fire = (state_q == StFinish) && out_free;
  assign div_last    = (cnt_q == bph_pkg::StepBits'(bph_pkg::DivSteps - 1));
  assign cmd_pop_o   = (state_q == StIdle) && cmd_valid_i;
  assign cnt_m1      = cnt_q - bph_pkg::StepBits'(1);

  // Control sequence: pop, load the scaled dividends, divide, report; a zero capacity skips to the report.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          state_d = cmd_i.zero_cap ? StFinish : StLoad;
        end
      end
      StLoad: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_last) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // One restoring division step for each quotient, shared step counter.
  assign pct_trial = {pct_rem_q, pct_num_q[bph_pkg::NumBits-1]};
  assign pct_ge    = (pct_trial >= {1'b0, cap_q});
  assign lat_trial = {lat_rem_q, lat_num_q[bph_pkg::NumBits-1]};
  assign lat_ge    = (lat_trial >= {1'b0, cfg_i.sample_rate});

  // Threshold picked for the comparator in the current step.
  always_comb begin
    case (cnt_q[bph_pkg::ThrBits-1:0])
      bph_pkg::ThrDegEnter:   thr_sel = cfg_i.degraded_enter;
      bph_pkg::ThrEmerEnter:  thr_sel = cfg_i.emergency_enter;
      bph_pkg::ThrDegRelease: thr_sel = cfg_i.degraded_release;
      default:                thr_sel = cfg_i.emergency_release;
    endcase
  end

  assign fill_scaled = bph_pkg::ProdBits'({fill_q, {bph_pkg::FracBits{1'b0}}});

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          fill_q <= cmd_i.fill;
          cap_q  <= cmd_i.cap;
          zero_q <= cmd_i.zero_cap;
        end
      end
      StLoad: begin
        pct_num_q <= bph_pkg::NumBits'(fill_q) * bph_pkg::NumBits'(bph_pkg::PctScale);
        lat_num_q <= bph_pkg::NumBits'(fill_q) * bph_pkg::NumBits'(bph_pkg::LatScale);
        pct_rem_q <= '0;
        lat_rem_q <= '0;
        cnt_q     <= '0;
      end
      StDiv: begin
        pct_rem_q <= pct_ge ? bph_pkg::CountBits'(pct_trial - {1'b0, cap_q})
                            : bph_pkg::CountBits'(pct_trial);
        pct_num_q <= {pct_num_q[bph_pkg::NumBits-2:0], pct_ge};
        lat_rem_q <= lat_ge ? bph_pkg::SampleRateBits'(lat_trial - {1'b0, cfg_i.sample_rate})
                            : bph_pkg::SampleRateBits'(lat_trial);
        lat_num_q <= {lat_num_q[bph_pkg::NumBits-2:0], lat_ge};
        cnt_q     <= cnt_q + bph_pkg::StepBits'(1);
        // Threshold products in the first steps, each compared a step later.
        if (cnt_q < bph_pkg::StepBits'(bph_pkg::NumThr)) begin
          prod_q <= bph_pkg::ProdBits'(thr_sel) * bph_pkg::ProdBits'(cap_q);
        end
        if ((cnt_q != '0) && (cnt_q <= bph_pkg::StepBits'(bph_pkg::NumThr))) begin
          flags_q[cnt_m1[bph_pkg::ThrBits-1:0]] <= (fill_scaled >= prod_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign ge_de = flags_q[bph_pkg::ThrDegEnter];
  assign ge_ee = flags_q[bph_pkg::ThrEmerEnter];
  assign ge_dr = flags_q[bph_pkg::ThrDegRelease];
  assign ge_er = flags_q[bph_pkg::ThrEmerRelease];

  // Hysteresis transitions of the flow mode.
  always_comb begin
    mode_nxt = mode_q;
    case (mode_q)
      bph_pkg::ModeNormal: begin
        if (ge_ee) begin
          mode_nxt = bph_pkg::ModeEmergency;
        end else if (ge_de) begin
          mode_nxt = bph_pkg::ModeDegraded;
        end
      end
      bph_pkg::ModeDegraded: begin
        if (ge_ee) begin
          mode_nxt = bph_pkg::ModeEmergency;
        end else if (!ge_dr) begin
          mode_nxt = bph_pkg::ModeNormal;
        end
      end
      bph_pkg::ModeEmergency: begin
        if (!ge_er) begin
          mode_nxt = ge_dr ? bph_pkg::ModeDegraded : bph_pkg::ModeNormal;
        end
      end
      default: begin
        mode_nxt = mode_q;
      end
    endcase
  end

  // Clamp the percent and saturate the latency.
  assign pct_new = (pct_num_q > bph_pkg::NumBits'(bph_pkg::PctMax))
                   ? bph_pkg::PctMax : pct_num_q[bph_pkg::PctBits-1:0];
  assign lat_new = (lat_num_q > bph_pkg::NumBits'(bph_pkg::LatMax))
                   ? bph_pkg::LatMax : lat_num_q[bph_pkg::LatBits-1:0];

  // Control state, stored flow state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= bph_pkg::ModeNormal;
      last_pct_q  <= '0;
      last_lat_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish_fire) begin
        out_valid_q <= 1'b1;
        if (!zero_q) begin
          mode_q     <= mode_nxt;
          last_pct_q <= pct_new;
          last_lat_q <= lat_new;
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (finish_fire) begin
      if (zero_q) begin
        out_mode_q <= bph_pkg::ModeNormal;
        out_pct_q  <= last_pct_q;
        out_lat_q  <= last_lat_q;
      end else begin
        out_mode_q <= mode_nxt;
        out_pct_q  <= pct_new;
        out_lat_q  <= lat_new;
      end
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.flow_mode        = out_mode_q;
  assign out_o.pressure_percent = out_pct_q;
  assign out_o.latency_ms       = out_lat_q;

  // The stored percent is always clamped.
  a_pct_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_pct_q <= bph_pkg::PctMax)
    else $error("stored percent above clamp");

  // A zero-capacity sample leaves the flow mode untouched.
  a_zero_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (finish_fire && zero_q) |=> (mode_q == $past(mode_q)))
    else $error("zero capacity changed the flow mode");

  // The last division step always hands over to the report step.
  a_div_to_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDiv) && div_last) |=> (state_q == StFinish))
    else $error("divider did not finish");

  // A popped command starts either the arithmetic or a direct report.
  a_pop_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> ((state_q == StLoad) || (state_q == StFinish)))
    else $error("popped command not dispatched");

endmodule

@@ rtl/buffer_pressure_hysteresis_fsm.sv @@
// ----------------------------------------------------------------------------
// Buffer pressure hysteresis controller
// Each sample passes the front-end register stage and the command queue to the
// back end, which runs the 34-step restoring dividers and takes a new sample only
// after reporting the last; zero-capacity samples skip the load and divide states.
// Reset: asynchronous, active low; mode normal, stored percent and latency cleared,
// registers at their default thresholds and a 48000 sample rate.
// ----------------------------------------------------------------------------
module buffer_pressure_hysteresis_fsm (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  bph_in_if.sink                             in_i,
  bph_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [bph_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [bph_pkg::CfgDataBits-1:0]    cfg_data_i
);

  bph_pkg::cfg_t cfg_q;
  bph_pkg::cmd_t front_cmd, queue_cmd;
  logic          front_valid, queue_full, queue_empty, back_pop;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate       <= bph_pkg::SampleRateRst;
      cfg_q.degraded_enter    <= bph_pkg::DegEnterRst;
      cfg_q.emergency_enter   <= bph_pkg::EmerEnterRst;
      cfg_q.degraded_release  <= bph_pkg::DegReleaseRst;
      cfg_q.emergency_release <= bph_pkg::EmerReleaseRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bph_pkg::CfgSampleRate:  cfg_q.sample_rate <= cfg_data_i;
        bph_pkg::CfgDegEnter:    cfg_q.degraded_enter <= cfg_data_i[bph_pkg::ThreshBits-1:0];
        bph_pkg::CfgEmerEnter:   cfg_q.emergency_enter <= cfg_data_i[bph_pkg::ThreshBits-1:0];
        bph_pkg::CfgDegRelease:  cfg_q.degraded_release <= cfg_data_i[bph_pkg::ThreshBits-1:0];
        bph_pkg::CfgEmerRelease: cfg_q.emergency_release <= cfg_data_i[bph_pkg::ThreshBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: sample intake and classification.
  bph_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (!queue_full)
  );

  // Queue between the two halves.
  bph_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .cmd_o   (queue_cmd),
    .empty_o (queue_empty)
  );

  // Back end: arithmetic, mode update and report.
  bph_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (!queue_empty),
    .cmd_pop_o   (back_pop),
    .out_o       (out_o)
  );

endmodule
